FILE: rtl/core/dtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types, constants and helpers of the date text parser.
// ----------------------------------------------------------------------------
package dtp_pkg;

  // character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // field widths
  localparam int unsigned ACC_W   = 16;
  localparam int unsigned SLOT_W  = 2;
  localparam int unsigned EPOCH_W = 14;
  localparam int unsigned CENT_W  = 8;
  localparam int unsigned REM_W   = 7;

  // register reset values
  localparam logic [SLOT_W-1:0]  DAY_SLOT_RST   = 2'd2;
  localparam logic [SLOT_W-1:0]  MONTH_SLOT_RST = 2'd1;
  localparam logic [SLOT_W-1:0]  YEAR_SLOT_RST  = 2'd3;
  localparam logic [EPOCH_W-1:0] EPOCH_RST      = 14'd1900;
  localparam logic [CENT_W-1:0]  CENT_RST       = 8'd19;

  // divide by 100 through a reciprocal, exact for all 14-bit values
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  localparam logic [ACC_W-1:0] ACC_MAX     = 16'hFFFF;
  localparam logic [ACC_W-1:0] HUNDRED     = 16'd100;
  localparam logic [SLOT_W-1:0] SLOT_FIRST = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_NONE  = 2'd0;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DAY_SLOT   = 2'd0,
    REG_MONTH_SLOT = 2'd1,
    REG_YEAR_SLOT  = 2'd2,
    REG_EPOCH_YEAR = 2'd3
  } dtp_reg_t;

  // hundred-year window derived from the epoch
  typedef struct packed {
    logic [EPOCH_W-1:0] base;
    logic [REM_W-1:0]   rem;
  } dtp_window_t;

  // one parsed date
  typedef struct packed {
    logic [ACC_W-1:0] day_value;
    logic [ACC_W-1:0] month_value;
    logic [ACC_W-1:0] year_value;
  } dtp_result_t;

  // decimal accumulate with saturation
  function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
                                                 input logic [3:0] d);
    logic [ACC_W+3:0] v;
    v = {acc, 3'b000} + {3'b000, acc, 1'b0} + {{ACC_W{1'b0}}, d};
    acc_digit = (v > {4'b0000, ACC_MAX}) ? ACC_MAX : v[ACC_W-1:0];
  endfunction

  // slot counter step toward zero
  function automatic logic [SLOT_W-1:0] dec_clamp(input logic [SLOT_W-1:0] c);
    dec_clamp = (c == SLOT_NONE) ? SLOT_NONE : c - 2'd1;
  endfunction

endpackage

FILE: rtl/core/date_text_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_text_parser
// Parses a date string, one character per item, into year, month and day.
// ----------------------------------------------------------------------------
//  channel  direction  handshake        payload
//  in_      input      tvalid/tready    tdata = char_code, tuser = char_valid,
//                                       tlast = end_of_text
//  out_     output     tvalid/tready    tdata = year, month, day (16 b each)
//  cfg_     input      we               addr = register index, wdata
//
//  one item per cycle sustained while results are taken; a character goes
//  through the input register and is folded into the field state on the next
//  edge, the result of an end-of-text item then goes through the result register.
//  rst_n is synchronous: slots return to day 2, month 1, year 3, epoch 1900.
//  a waiting result stalls only an end-of-text item and the input behind it;
//  other characters keep flowing. register writes act on the next item.
// ----------------------------------------------------------------------------
module date_text_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  // input items
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] char_code
  input  logic [0:0]                   in_tuser,   // [0] char_valid
  input  logic                         in_tlast,   // end_of_text
  // result items
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [47:0]                  out_tdata,  // [15:0] year, [31:16] month,
                                                   // [47:32] day
  // configuration
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_addr,
  input  logic [dtp_pkg::EPOCH_W-1:0]  cfg_wdata
);

  logic                  s1_v_r;
  logic [7:0]            s1_char_r;
  logic                  s1_cvalid_r;
  logic                  s1_last_r;
  logic                  s1_go;
  logic                  out_free;
  logic                  out_v_r;
  dtp_pkg::dtp_result_t  out_r;
  dtp_pkg::dtp_result_t  result;
  dtp_pkg::dtp_window_t  window;

  // flow control
  assign out_free  = !out_v_r || out_tready;
  assign s1_go     = s1_v_r && (!s1_last_r || out_free);
  assign in_tready = !s1_v_r || s1_go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r   <= in_tdata;
      s1_cvalid_r <= in_tuser[0];
      s1_last_r   <= in_tlast;
    end
  end

  dtp_epoch u_epoch (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .window    (window)
  );

  dtp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .window      (window),
    .item_go     (s1_go),
    .char_code   (s1_char_r),
    .char_valid  (s1_cvalid_r),
    .end_of_text (s1_last_r),
    .result      (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.day_value, out_r.month_value, out_r.year_value};

endmodule

FILE: rtl/core/dtp_epoch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_epoch
// Epoch register and its century split, base = epoch rounded down to 100.
// ----------------------------------------------------------------------------
module dtp_epoch (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_addr,
  input  logic [dtp_pkg::EPOCH_W-1:0]     cfg_wdata,
  output dtp_pkg::dtp_window_t            window
);

  logic [dtp_pkg::EPOCH_W-1:0] epoch_r;
  logic [dtp_pkg::CENT_W-1:0]  cent_r;
  logic [dtp_pkg::CENT_W-1:0]  cent_nxt;
  logic [26:0]                 prod;
  logic [14:0]                 base_full;
  logic [dtp_pkg::EPOCH_W-1:0] diff;

  // epoch register, century loaded together with it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= dtp_pkg::EPOCH_RST;
      cent_r  <= dtp_pkg::CENT_RST;
    end else begin
      if (cfg_we && (cfg_addr == dtp_pkg::REG_EPOCH_YEAR)) begin
        epoch_r <= cfg_wdata;
        cent_r  <= cent_nxt;
      end
    end
  end

  // century of the written value by reciprocal multiply
  always_comb begin
    prod     = {13'd0, cfg_wdata} * {14'd0, dtp_pkg::DIV100_MUL};
    cent_nxt = prod[dtp_pkg::DIV100_SHIFT +: dtp_pkg::CENT_W];
  end

  // base and remainder from the registered century
  always_comb begin
    base_full   = {7'd0, cent_r} * 15'd100;
    diff        = epoch_r - base_full[dtp_pkg::EPOCH_W-1:0];
    window.base = base_full[dtp_pkg::EPOCH_W-1:0];
    window.rem  = diff[dtp_pkg::REM_W-1:0];
  end

endmodule

FILE: rtl/core/dtp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_parse
// Slot registers, slot counters and field accumulators; one item per cycle while item_go is set.
// ----------------------------------------------------------------------------
module dtp_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_addr,
  input  logic [dtp_pkg::EPOCH_W-1:0]   cfg_wdata,
  input  dtp_pkg::dtp_window_t          window,
  input  logic                          item_go,
  input  logic [7:0]                    char_code,
  input  logic                          char_valid,
  input  logic                          end_of_text,
  output dtp_pkg::dtp_result_t          result
);

  logic [dtp_pkg::SLOT_W-1:0] day_slot_r, month_slot_r, year_slot_r;
  logic [dtp_pkg::SLOT_W-1:0] day_cnt_r, month_cnt_r, year_cnt_r;
  logic [dtp_pkg::SLOT_W-1:0] day_cnt_nxt, month_cnt_nxt, year_cnt_nxt;
  logic [dtp_pkg::ACC_W-1:0]  day_acc_r, month_acc_r, year_acc_r;
  logic [dtp_pkg::ACC_W-1:0]  day_acc_nxt, month_acc_nxt, year_acc_nxt;
  logic                       skip_r, skip_nxt;
  logic                       is_digit, is_sep;
  logic [3:0]                 digit;
  logic [dtp_pkg::ACC_W-1:0]  year_win;

  // character class
  always_comb begin
    is_digit = char_valid && (char_code inside {[dtp_pkg::CHAR_ZERO:dtp_pkg::CHAR_NINE]});
    is_sep   = char_valid && !is_digit && (char_code != dtp_pkg::CHAR_SPACE);
    digit    = char_code[3:0];
  end

  // field update for one character
  always_comb begin
    day_cnt_nxt   = day_cnt_r;
    month_cnt_nxt = month_cnt_r;
    year_cnt_nxt  = year_cnt_r;
    day_acc_nxt   = day_acc_r;
    month_acc_nxt = month_acc_r;
    year_acc_nxt  = year_acc_r;
    skip_nxt      = skip_r;
    if (is_digit) begin
      if (day_cnt_r == dtp_pkg::SLOT_FIRST) begin
        day_acc_nxt = dtp_pkg::acc_digit(day_acc_r, digit);
      end else if (month_cnt_r == dtp_pkg::SLOT_FIRST) begin
        month_acc_nxt = dtp_pkg::acc_digit(month_acc_r, digit);
      end else if (year_cnt_r == dtp_pkg::SLOT_FIRST) begin
        year_acc_nxt = dtp_pkg::acc_digit(year_acc_r, digit);
      end
      skip_nxt = 1'b0;
    end else if (is_sep) begin
      if (!skip_r) begin
        day_cnt_nxt   = dtp_pkg::dec_clamp(day_cnt_r);
        month_cnt_nxt = dtp_pkg::dec_clamp(month_cnt_r);
        year_cnt_nxt  = dtp_pkg::dec_clamp(year_cnt_r);
      end
      skip_nxt = 1'b1;
    end
  end

  // two-digit year windowing
  always_comb begin
    year_win = year_acc_nxt;
    if (year_acc_nxt < dtp_pkg::HUNDRED) begin
      year_win = {2'b00, window.base} + year_acc_nxt;
      if (year_acc_nxt[dtp_pkg::REM_W-1:0] < window.rem) begin
        year_win = {2'b00, window.base} + year_acc_nxt + dtp_pkg::HUNDRED;
      end
    end
    result.year_value  = year_win;
    result.month_value = month_acc_nxt;
    result.day_value   = day_acc_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_slot_r   <= dtp_pkg::DAY_SLOT_RST;
      month_slot_r <= dtp_pkg::MONTH_SLOT_RST;
      year_slot_r  <= dtp_pkg::YEAR_SLOT_RST;
      day_cnt_r    <= dtp_pkg::DAY_SLOT_RST;
      month_cnt_r  <= dtp_pkg::MONTH_SLOT_RST;
      year_cnt_r   <= dtp_pkg::YEAR_SLOT_RST;
      day_acc_r    <= '0;
      month_acc_r  <= '0;
      year_acc_r   <= '0;
      skip_r       <= 1'b1;
    end else begin
      if (item_go) begin
        if (end_of_text) begin
          day_cnt_r   <= day_slot_r;
          month_cnt_r <= month_slot_r;
          year_cnt_r  <= year_slot_r;
          day_acc_r   <= '0;
          month_acc_r <= '0;
          year_acc_r  <= '0;
          skip_r      <= 1'b1;
        end else begin
          day_cnt_r   <= day_cnt_nxt;
          month_cnt_r <= month_cnt_nxt;
          year_cnt_r  <= year_cnt_nxt;
          day_acc_r   <= day_acc_nxt;
          month_acc_r <= month_acc_nxt;
          year_acc_r  <= year_acc_nxt;
          skip_r      <= skip_nxt;
        end
      end
      // slot writes also load the live counter
      if (cfg_we) begin
        case (dtp_pkg::dtp_reg_t'(cfg_addr))
          dtp_pkg::REG_DAY_SLOT: begin
            day_slot_r <= cfg_wdata[dtp_pkg::SLOT_W-1:0];
            day_cnt_r  <= cfg_wdata[dtp_pkg::SLOT_W-1:0];
          end
          dtp_pkg::REG_MONTH_SLOT: begin
            month_slot_r <= cfg_wdata[dtp_pkg::SLOT_W-1:0];
            month_cnt_r  <= cfg_wdata[dtp_pkg::SLOT_W-1:0];
          end
          dtp_pkg::REG_YEAR_SLOT: begin
            year_slot_r <= cfg_wdata[dtp_pkg::SLOT_W-1:0];
            year_cnt_r  <= cfg_wdata[dtp_pkg::SLOT_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: rtl/core/dtp_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_chk
// Port-level checks of the date text parser, bound to the top level.
// ----------------------------------------------------------------------------
module dtp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its fields
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // reset empties the input register, so an item can enter at once
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready right after reset");

endmodule

bind date_text_parser dtp_chk u_dtp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: dv/date_text_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_text_parser_test
// Streams date strings into the parser one character per item, under several
// field orders and epochs, and compares every parsed date against a typed
// date or a behavioral model of slot counters, accumulators, year windowing.
// ----------------------------------------------------------------------------
module date_text_parser_test;
  import dtp_pkg::*;

  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 50;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned LONG_HOLD   = 400;

  // sender gap and receiver stall percentages per phase
  localparam int GAP_PCT   [PHASES] = '{0, 58, 0, 10, 0, 58, 0, 10};
  localparam int STALL_PCT [PHASES] = '{0, 0, 58, 10, 0, 0, 58, 10};

  // one character item, with an optional hand-written expected date
  typedef struct packed {
    logic [7:0]  code;
    logic        valid;
    logic        last;
    logic        typed;
    dtp_result_t want;
  } char_item_t;

  localparam dtp_result_t NO_DATE = '0;

  // directed strings; dates are {day, month, year}
  localparam int unsigned N_DIRECTED = 22;
  localparam char_item_t DIRECTED [N_DIRECTED] = '{
    // "12/31/99" with the default month-day-year order
    '{"1", 1'b1, 1'b0, 1'b0, NO_DATE},
    '{"2", 1'b1, 1'b0, 1'b0, NO_DATE},
    '{"/", 1'b1, 1'b0, 1'b0, NO_DATE},
    '{"3", 1'b1, 1'b0, 1'b0, NO_DATE},
    '{"1", 1'b1, 1'b0, 1'b0, NO_DATE},
    '{"/", 1'b1, 1'b0, 1'b0, NO_DATE},
    '{"9", 1'b1, 1'b0, 1'b0, NO_DATE},
    '{"9", 1'b1, 1'b1, 1'b1, '{16'd31, 16'd12, 16'd1999}},
    // empty string, end marker only
    '{8'h00, 1'b0, 1'b1, 1'b1, '{16'd0, 16'd0, 16'd1900}},
    // month saturates, ended by a space
    '{"9", 1'b1, 1'b0, 1'b0, NO_DATE},
    '{"9", 1'b1, 1'b0, 1'b0, NO_DATE},
    '{"9", 1'b1, 1'b0, 1'b0, NO_DATE},
    '{"9", 1'b1, 1'b0, 1'b0, NO_DATE},
    '{"9", 1'b1, 1'b0, 1'b0, NO_DATE},
    '{" ", 1'b1, 1'b1, 1'b1, '{16'd0, 16'd65535, 16'd1900}},
    // leading junk, doubled separators, null byte, ignored end character
    '{8'hFF, 1'b1, 1'b0, 1'b0, NO_DATE},
    '{"3", 1'b1, 1'b0, 1'b0, NO_DATE},
    '{"-", 1'b1, 1'b0, 1'b0, NO_DATE},
    '{"-", 1'b1, 1'b0, 1'b0, NO_DATE},
    '{8'h00, 1'b1, 1'b0, 1'b0, NO_DATE},
    '{"7", 1'b1, 1'b0, 1'b0, NO_DATE},
    '{"5", 1'b0, 1'b1, 1'b1, '{16'd7, 16'd3, 16'd1900}}
  };

  // parser state as the model sees it
  typedef struct {
    logic [SLOT_W-1:0]  slot_day, slot_month, slot_year;
    logic [EPOCH_W-1:0] epoch;
    logic [SLOT_W-1:0]  cnt_day, cnt_month, cnt_year;
    logic [ACC_W-1:0]   acc_day, acc_month, acc_year;
    logic               skip_sep;
  } parse_state_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata = '0;
  logic [0:0]         in_tuser = '0;
  logic               in_tlast = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [47:0]        out_tdata;
  logic               cfg_we = 1'b0;
  dtp_reg_t           cfg_addr = REG_DAY_SLOT;
  logic [EPOCH_W-1:0] cfg_wdata = '0;

  parse_state_t fields;
  char_item_t   pending_chars [$];
  dtp_result_t  expected_dates [$];
  char_item_t   on_bus;
  int           gap_pct = 0;
  int           stall_pct = 0;
  logic         out_hold = 1'b0;
  event         hold_go;
  int           err_count = 0;
  int unsigned  work_items = 0;

  date_text_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // date model
  // ---------------------------------------------------------------------------

  // counters from the slot registers, empty accumulators
  function automatic void restart_fields();
    fields.cnt_day   = fields.slot_day;
    fields.cnt_month = fields.slot_month;
    fields.cnt_year  = fields.slot_year;
    fields.acc_day   = '0;
    fields.acc_month = '0;
    fields.acc_year  = '0;
    fields.skip_sep  = 1'b1;
  endfunction

  // times ten plus digit, saturating at the top of 16 bits
  function automatic logic [ACC_W-1:0] decimal_push(logic [ACC_W-1:0] acc,
                                                    logic [3:0] d);
    int unsigned v;
    v = acc * 10 + d;
    return (v > 65535) ? 16'hFFFF : v[ACC_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] step_down(logic [SLOT_W-1:0] c);
    return (c == SLOT_NONE) ? SLOT_NONE : c - 2'd1;
  endfunction

  // fold one character in; returns 1 and the date on end of text
  function automatic bit parse_char(char_item_t it, output dtp_result_t date);
    int unsigned y;
    int unsigned century;
    date = '0;
    if (it.valid) begin
      if (it.code >= CHAR_ZERO && it.code <= CHAR_NINE) begin
        if (fields.cnt_day == SLOT_FIRST)
          fields.acc_day = decimal_push(fields.acc_day, 4'(it.code - CHAR_ZERO));
        else if (fields.cnt_month == SLOT_FIRST)
          fields.acc_month = decimal_push(fields.acc_month, 4'(it.code - CHAR_ZERO));
        else if (fields.cnt_year == SLOT_FIRST)
          fields.acc_year = decimal_push(fields.acc_year, 4'(it.code - CHAR_ZERO));
        fields.skip_sep = 1'b0;
      end else if (it.code != CHAR_SPACE) begin
        if (!fields.skip_sep) begin
          fields.cnt_day   = step_down(fields.cnt_day);
          fields.cnt_month = step_down(fields.cnt_month);
          fields.cnt_year  = step_down(fields.cnt_year);
        end
        fields.skip_sep = 1'b1;
      end
    end
    if (!it.last) return 1'b0;
    // two-digit years land in the window that starts at the epoch
    y = fields.acc_year;
    if (y < 100) begin
      century = (fields.epoch / 100) * 100;
      y += (y >= fields.epoch % 100) ? century : century + 100;
    end
    date.year_value  = y[ACC_W-1:0];
    date.month_value = fields.acc_month;
    date.day_value   = fields.acc_day;
    restart_fields();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // string generation
  // ---------------------------------------------------------------------------

  function automatic void push_char(logic [7:0] code, logic valid, logic last);
    char_item_t it;
    it = '{code, valid, last, 1'b0, NO_DATE};
    pending_chars.push_back(it);
    if (last || (valid && code != CHAR_SPACE)) work_items++;
  endfunction

  function automatic logic [7:0] pick_sep();
    logic [7:0] c;
    case ($urandom_range(3))
      0: c = "/";
      1: c = "-";
      2: c = ".";
      default: begin
        do c = 8'($urandom_range(255));
        while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_SPACE);
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pick_digit();
    return CHAR_ZERO + 8'($urandom_range(9));
  endfunction

  // mostly well-formed dates with random content, some pure noise
  function automatic void gen_date(bit finish);
    int n_fields;
    int n_digits;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(8, 1))
        push_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
    end else begin
      repeat ($urandom_range(2)) push_char(pick_sep(), 1'b1, 1'b0);
      n_fields = ($urandom_range(4) == 0) ? $urandom_range(4, 1) : 3;
      for (int f = 0; f < n_fields; f++) begin
        if (f > 0) repeat ($urandom_range(2, 1)) push_char(pick_sep(), 1'b1, 1'b0);
        n_digits = ($urandom_range(19) == 0) ? $urandom_range(6, 5) : $urandom_range(4, 1);
        for (int d = 0; d < n_digits; d++) begin
          push_char(pick_digit(), 1'b1, 1'b0);
          // stray spaces and empty items inside a field
          if ($urandom_range(19) == 0) push_char(CHAR_SPACE, 1'b1, 1'b0);
          if ($urandom_range(19) == 0) push_char(8'($urandom_range(255)), 1'b0, 1'b0);
        end
      end
    end
    if (finish) begin
      case ($urandom_range(3))
        0: push_char(8'($urandom_range(255)), 1'b0, 1'b1);
        1: push_char(pick_digit(), 1'b1, 1'b1);
        2: push_char(pick_sep(), 1'b1, 1'b1);
        default: push_char(CHAR_SPACE, 1'b1, 1'b1);
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: predicts on each accepted item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_chars
    dtp_result_t date;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (parse_char(on_bus, date))
          expected_dates.push_back(on_bus.typed ? on_bus.want : date);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= gap_pct) begin
          on_bus = pending_chars.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= on_bus.code;
          in_tuser  <= on_bus.valid;
          in_tlast  <= on_bus.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver with random stalls and a forced hold-off
  always @(posedge clk) begin
    if (out_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off, counted in cycles here
  initial begin : long_hold
    @(hold_go);
    out_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    out_hold <= 1'b0;
  end

  // compare each accepted date with the oldest prediction
  always @(posedge clk) begin : check_dates
    dtp_result_t got;
    dtp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_dates.size() == 0) begin
        err_count++;
        $display("%0t: unexpected date y/m/d %0d/%0d/%0d", $realtime,
                 got.year_value, got.month_value, got.day_value);
      end else begin
        want = expected_dates.pop_front();
        if (got != want) begin
          err_count++;
          $display("%0t: date mismatch, expected y/m/d %0d/%0d/%0d, got %0d/%0d/%0d",
                   $realtime, want.year_value, want.month_value, want.day_value,
                   got.year_value, got.month_value, got.day_value);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing
  // ---------------------------------------------------------------------------

  // register write, mirrored into the model; caller drops cfg_we afterwards
  task automatic write_reg(dtp_reg_t r, logic [EPOCH_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    case (r)
      REG_DAY_SLOT: begin
        fields.slot_day = v[SLOT_W-1:0];
        fields.cnt_day  = v[SLOT_W-1:0];
      end
      REG_MONTH_SLOT: begin
        fields.slot_month = v[SLOT_W-1:0];
        fields.cnt_month  = v[SLOT_W-1:0];
      end
      REG_YEAR_SLOT: begin
        fields.slot_year = v[SLOT_W-1:0];
        fields.cnt_year  = v[SLOT_W-1:0];
      end
      default: fields.epoch = v;
    endcase
    @(posedge clk);
  endtask

  // wait until every item is in and every date is out, then let it settle
  task automatic drain();
    while (pending_chars.size() != 0 || in_tvalid || expected_dates.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [EPOCH_W-1:0] w_day, w_month, w_year, w_epoch;
    int unsigned phase_end;

    fields.slot_day   = DAY_SLOT_RST;
    fields.slot_month = MONTH_SLOT_RST;
    fields.slot_year  = YEAR_SLOT_RST;
    fields.epoch      = EPOCH_RST;
    restart_fields();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings under reset settings
    for (int i = 0; i < N_DIRECTED; i++) pending_chars.push_back(DIRECTED[i]);
    drain();

    // slot write in the middle of a string takes effect at once
    push_char("4", 1'b1, 1'b0);
    drain();
    write_reg(REG_DAY_SLOT, 14'd1);
    cfg_we <= 1'b0;
    @(posedge clk);
    push_char("5", 1'b1, 1'b1);
    drain();

    // random phases: new settings, idling mix, random dates
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin w_day = 14'd1; w_month = 14'd2; w_year = 14'd3; w_epoch = 14'd0; end
        1: begin w_day = 14'd3; w_month = 14'd2; w_year = 14'd1; w_epoch = 14'd9999; end
        2: begin w_day = 14'd0; w_month = 14'd0; w_year = 14'd0; w_epoch = 14'h3FFF; end
        3: begin w_day = 14'd3; w_month = 14'd3; w_year = 14'd3; w_epoch = 14'd1950; end
        default: begin
          w_day   = 14'($urandom);
          w_month = 14'($urandom);
          w_year  = 14'($urandom);
          w_epoch = ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(9999));
        end
      endcase
      write_reg(REG_DAY_SLOT, w_day);
      write_reg(REG_MONTH_SLOT, w_month);
      write_reg(REG_YEAR_SLOT, w_year);
      write_reg(REG_EPOCH_YEAR, w_epoch);
      cfg_we    <= 1'b0;
      gap_pct   <= GAP_PCT[p];
      stall_pct <= STALL_PCT[p];
      @(posedge clk);

      // long receiver hold-off so the parser backs up into its input
      if (p == 4) -> hold_go;
      phase_end = work_items + PHASE_ITEMS;
      while (work_items < phase_end) gen_date(1'b1);
      // sometimes leave a string open across the next register writes
      if ($urandom_range(1)) gen_date(1'b0);
      drain();
    end

    // close any open string and finish
    push_char(8'h00, 1'b0, 1'b1);
    drain();
    repeat (10) @(posedge clk);
    if (err_count == 0 && expected_dates.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
